>>> design/tile_column_rle_decoder_core_assert.svh
// Assertion macros for the decoder datapath.
// Each macro expects clk_i and rst_ni in scope.
`ifndef TILE_COLUMN_RLE_DECODER_CORE_ASSERT_SVH
`define TILE_COLUMN_RLE_DECODER_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define TCRD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TCRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TCRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tcrd_pkg.sv
package tcrd_pkg;

  // Geometry of the tile map
  localparam int ROWS         = 24;
  localparam int COLUMNS      = 32;
  localparam int RESULT_LIMIT = 24;

  localparam int RowW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int CntW = $clog2(RESULT_LIMIT + 1);

  // Port field widths
  localparam int InDataW   = 8;
  localparam int InUserW   = 2;
  localparam int ColFieldW = 5;
  localparam int RowFieldW = 5;
  localparam int OutPackW  = ColFieldW + RowFieldW + 8 + 1 + 8;
  localparam int OutDataW  = ((OutPackW + 7) / 8) * 8;
  localparam int OutPadW   = OutDataW - OutPackW;

  localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_REPLAY  = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  // Parser position within a column
  typedef enum logic [1:0] {
    PH_START     = 2'd0,
    PH_BODY      = 2'd1,
    PH_START_ESC = 2'd2,
    PH_BODY_ESC  = 2'd3
  } phase_e;

  // Work that one decoded word leads to
  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_RUN    = 2'd1,
    JOB_REPLAY = 2'd2
  } job_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_RUN    = 3'd2,
    ST_REPLAY = 3'd3,
    ST_STATUS = 3'd4
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic decode;
    logic run_step;
    logic replay_step;
    logic status_step;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    job_e job;
    logic can_step;
    logic run_last;
    logic replay_last;
  } dp_stat_t;

endpackage

>>> design/tcrd_ctrl.sv
module tcrd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcrd_pkg::dp_stat_t stat_i,
  output tcrd_pkg::dp_cmd_t  cmd_o
);
  import tcrd_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.job)
          JOB_RUN:    state_d = ST_RUN;
          JOB_REPLAY: state_d = ST_REPLAY;
          default:    state_d = ST_STATUS;
        endcase
      end
      ST_RUN: begin
        if (stat_i.can_step && stat_i.run_last) state_d = ST_IDLE;
      end
      ST_REPLAY: begin
        if (stat_i.can_step && stat_i.replay_last) state_d = ST_IDLE;
      end
      ST_STATUS: begin
        if (stat_i.can_step) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o        = (state_q == ST_IDLE);
    cmd_o.latch       = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.decode      = (state_q == ST_DECODE);
    cmd_o.run_step    = (state_q == ST_RUN) && stat_i.can_step;
    cmd_o.replay_step = (state_q == ST_REPLAY) && stat_i.can_step;
    cmd_o.status_step = (state_q == ST_STATUS) && stat_i.can_step;
  end

endmodule

>>> design/tcrd_datapath.sv
`include "tile_column_rle_decoder_core_assert.svh"

module tcrd_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcrd_pkg::dp_cmd_t             cmd_i,
  output tcrd_pkg::dp_stat_t            stat_o,
  input  logic [tcrd_pkg::InUserW-1:0]  in_cmd_i,
  input  logic [tcrd_pkg::InDataW-1:0]  in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcrd_pkg::OutDataW-1:0] out_data_o,
  output logic                          out_user_o,
  output logic                          out_last_o
);
  import tcrd_pkg::*;

  // Latched input word
  logic [InUserW-1:0] cmd_q;
  logic [7:0]         byte_q;

  // Decoder state
  phase_e         phase_q, phase_d;
  logic [7:0]     prev_q, prev_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [7:0]     pend_q, pend_d;
  logic           ended_q, ended_d;
  logic [7:0]     store_q [ROWS];
  logic [7:0]     store_d [ROWS];

  // Current job
  logic [7:0]     tile_q, tile_d;
  logic [7:0]     runcnt_q, runcnt_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  job_e           job;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                out_user_q, out_user_d;
  logic                out_last_q, out_last_d;

  logic            is_esc;
  logic            row_end;
  logic [ColW-1:0] col_next;
  logic            emit_en;
  logic            any_step;
  logic            load;
  logic            step_last;
  logic [7:0]      emit_tile;

  assign is_esc   = (byte_q == ESCAPE_BYTE);
  assign row_end  = (row_q == RowW'(ROWS - 1));
  assign col_next = (col_q == ColW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
  assign emit_en  = (cnt_q < CntW'(RESULT_LIMIT));
  assign any_step = cmd_i.run_step || cmd_i.replay_step || cmd_i.status_step;
  assign load     = any_step && emit_en;

  // Classify the latched word
  always_comb begin
    job = JOB_STATUS;
    unique case (cmd_q)
      CMD_DATA: begin
        if (!ended_q && (pend_q == '0)) begin
          unique case (phase_q)
            PH_START, PH_BODY: job = is_esc ? JOB_STATUS : JOB_RUN;
            PH_START_ESC:      job = is_esc ? JOB_STATUS : JOB_REPLAY;
            PH_BODY_ESC:       job = (byte_q == '0) ? JOB_STATUS : JOB_RUN;
          endcase
        end
      end
      CMD_REPLAY: begin
        if (!ended_q && (pend_q != '0)) job = JOB_REPLAY;
      end
      default: job = JOB_STATUS;
    endcase
  end

  // Status toward the controller
  assign stat_o.job         = job;
  assign stat_o.can_step    = !out_valid_q || out_ready_i || !emit_en;
  assign stat_o.run_last    = (runcnt_q == 8'd1) || row_end;
  assign stat_o.replay_last = row_end;

  // Decode and step updates
  always_comb begin
    phase_d  = phase_q;
    prev_d   = prev_q;
    row_d    = row_q;
    col_d    = col_q;
    pend_d   = pend_q;
    ended_d  = ended_q;
    store_d  = store_q;
    tile_d   = tile_q;
    runcnt_d = runcnt_q;
    cnt_d    = cnt_q;

    if (cmd_i.decode) begin
      cnt_d = '0;
      unique case (cmd_q)
        CMD_DATA: begin
          if (!ended_q && (pend_q == '0)) begin
            unique case (phase_q)
              PH_START, PH_BODY: begin
                if (is_esc) begin
                  phase_d = (phase_q == PH_START) ? PH_START_ESC : PH_BODY_ESC;
                end else begin
                  phase_d  = PH_BODY;
                  prev_d   = byte_q;
                  tile_d   = byte_q;
                  runcnt_d = 8'd1;
                end
              end
              PH_START_ESC: begin
                if (is_esc) begin
                  ended_d = 1'b1;
                  phase_d = PH_START;
                end else begin
                  // a count of zero replays once, like a count of one
                  pend_d = (byte_q == '0) ? '0 : byte_q - 8'd1;
                end
              end
              PH_BODY_ESC: begin
                tile_d   = prev_q;
                prev_d   = byte_q;
                phase_d  = PH_BODY;
                runcnt_d = byte_q;
              end
            endcase
          end
        end
        CMD_REPLAY: begin
          if (!ended_q && (pend_q != '0)) pend_d = pend_q - 8'd1;
        end
        CMD_RESTART: begin
          phase_d = PH_START;
          prev_d  = '0;
          row_d   = '0;
          col_d   = '0;
          pend_d  = '0;
          ended_d = 1'b0;
          store_d = '{default: '0};
        end
        default: ;
      endcase
    end

    // Write one run tile into the column store
    if (cmd_i.run_step) begin
      store_d[row_q] = tile_q;
      runcnt_d       = runcnt_q - 8'd1;
    end

    // Advance the row, wrap into the next column at the bottom
    if (cmd_i.run_step || cmd_i.replay_step) begin
      if (row_end) begin
        row_d   = '0;
        col_d   = col_next;
        phase_d = PH_START;
      end else begin
        row_d = row_q + 1'b1;
      end
    end

    if (any_step && emit_en) cnt_d = cnt_q + 1'b1;
  end

  // Result word contents
  always_comb begin
    priority if (cmd_i.run_step) begin
      emit_tile = tile_q;
      step_last = stat_o.run_last;
    end else if (cmd_i.replay_step) begin
      emit_tile = store_q[row_q];
      step_last = row_end;
    end else begin
      emit_tile = '0;
      step_last = 1'b1;
    end
  end

  always_comb begin
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_data_d  = {OutPadW'(0), pend_q, ended_q, emit_tile,
                     RowFieldW'(row_q), ColFieldW'(col_q)};
      out_user_d  = !cmd_i.status_step;
      out_last_d  = step_last || (cnt_q == CntW'(RESULT_LIMIT - 1));
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      prev_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pend_q      <= '0;
      ended_q     <= 1'b0;
      store_q     <= '{default: '0};
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      prev_q      <= prev_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pend_q      <= pend_d;
      ended_q     <= ended_d;
      store_q     <= store_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= in_cmd_i;
      byte_q <= in_byte_i;
    end
    tile_q     <= tile_d;
    runcnt_q   <= runcnt_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  `TCRD_ASSERT_ALWAYS(a_row_in_range, row_q <= RowW'(ROWS - 1), "row index past column end")
  `TCRD_ASSERT_ALWAYS(a_one_step,
    $onehot0({cmd_i.run_step, cmd_i.replay_step, cmd_i.status_step}),
    "more than one step in a cycle")
  `TCRD_ASSERT_IMP(a_step_has_room, any_step, stat_o.can_step,
    "step issued while the result register is blocked")
  `TCRD_ASSERT_IMP(a_no_replay_after_end, pend_q != '0, !ended_q,
    "replays pending after level end")
  `TCRD_ASSERT_NEXT(a_load_shows, load, out_valid_q, "loaded result word not presented")

endmodule

>>> design/tile_column_rle_decoder_core.sv
// Tile column run-length decoder.
// Input channel s_axis: one word per level byte or command. tuser carries
// the command (data byte, replay one pending column, restart level), tdata
// the level byte. Output channel m_axis: one word per tile write, or one
// status word when an input writes no tile; tlast marks the final word of
// each input, tuser marks a tile write.
// Timing: an input word is taken in the idle state, decoded in the next
// cycle, and its results leave one per cycle after that while
// m_axis_tready stays high; each result is registered. A literal or status
// word gives one result, a column replay ROWS results. Only one result
// step is taken per cycle, writing the column store or reading it by row.
// Reset: the parser returns to column start at column 0 row 0, the stored
// previous column reads as all zero tiles, no replays pend. A restart
// command does the same and answers with one status word.
// Stall: the result register holds while m_axis_tready is low and the
// decoder waits with it; a new input word is taken as soon as the last
// result of the previous one sits in the result register.
module tile_column_rle_decoder_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tcrd_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] level_byte
  input  logic [tcrd_pkg::InUserW-1:0]  s_axis_tuser,  // [1:0] command
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [4:0] column, [9:5] row, [17:10] tile, [18] level_ended,
  // [26:19] repeats_left, [31:27] zero
  output logic [tcrd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tuser,  // [0] tile_valid
  output logic                          m_axis_tlast   // last
);
  import tcrd_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  tcrd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Parser state, column store and result register
  tcrd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .in_cmd_i    (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> test/tile_column_rle_decoder_core_tb.sv
module tile_column_rle_decoder_core_tb;
  import tcrd_pkg::*;

  localparam int CycleLimit    = 600000;
  localparam int DrainCycles   = 40;
  localparam int HoldOffCycles = 250;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One tile write or status word as it leaves the block
  typedef struct {
    logic [4:0] column;
    logic [4:0] row;
    logic [7:0] tile;
    logic       tile_valid;
    logic       last;
    logic       level_ended;
    logic [7:0] repeats_left;
  } tile_write_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [InUserW-1:0]  s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // Shadow of the decoder state
  phase_e      parse_ph;
  logic [7:0]  last_literal;
  int unsigned row_ptr;
  int unsigned col_ptr;
  logic [7:0]  columns_owed;
  logic        level_over;
  logic [7:0]  column_shadow [ROWS];
  tile_write_t item_writes[$];
  tile_write_t expected_writes[$];

  // Run bookkeeping
  int          mismatches;
  int          words_checked;
  int          items_sent;
  int          column_wraps;
  int          level_ends;
  int unsigned cycle_count;
  bit          tx_idle_on;
  bit          rx_idle_on;
  int          hold_requests;
  int          holds_seen;
  int          hold_left;
  int          rx_wait;

  tile_column_rle_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Return the shadow state to level start
  function automatic void decoder_clear();
    parse_ph     = PH_START;
    last_literal = '0;
    row_ptr      = 0;
    col_ptr      = 0;
    columns_owed = '0;
    level_over   = 1'b0;
    foreach (column_shadow[i]) column_shadow[i] = '0;
  endfunction

  // Record one word for the current input; drop anything past the result limit
  function automatic void log_write(int unsigned row, logic [7:0] tile, logic valid);
    tile_write_t w;
    if (item_writes.size() >= RESULT_LIMIT) return;
    w.column       = col_ptr[4:0];
    w.row          = row[4:0];
    w.tile         = tile;
    w.tile_valid   = valid;
    w.last         = 1'b0;
    w.level_ended  = level_over;
    w.repeats_left = columns_owed;
    item_writes.push_back(w);
  endfunction

  // Move to the top of the next column, wrapping at the map edge
  function automatic void next_column();
    if (col_ptr + 1 >= COLUMNS) begin
      col_ptr = 0;
      column_wraps++;
    end else begin
      col_ptr = col_ptr + 1;
    end
    row_ptr  = 0;
    parse_ph = PH_START;
  endfunction

  function automatic void place_tile(logic [7:0] tile);
    if (row_ptr < ROWS) begin
      column_shadow[row_ptr] = tile;
      log_write(row_ptr, tile, 1'b1);
      row_ptr++;
    end
    if (row_ptr >= ROWS) next_column();
  endfunction

  // Write the stored column again into the current one
  function automatic void replay_shadow();
    for (int r = 0; r < ROWS; r++) log_write(r, column_shadow[r], 1'b1);
    next_column();
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [7:0] fill;
    if (level_over || columns_owed != 0) return;
    case (parse_ph)
      PH_START: begin
        if (b == ESCAPE_BYTE) begin
          parse_ph = PH_START_ESC;
        end else begin
          parse_ph     = PH_BODY;
          last_literal = b;
          place_tile(b);
        end
      end
      PH_BODY: begin
        if (b == ESCAPE_BYTE) begin
          parse_ph = PH_BODY_ESC;
        end else begin
          last_literal = b;
          place_tile(b);
        end
      end
      PH_START_ESC: begin
        if (b == ESCAPE_BYTE) begin
          level_over = 1'b1;
          parse_ph   = PH_START;
          level_ends++;
        end else begin
          // a replay count of zero still replays once
          columns_owed = (b == 8'd0) ? 8'd0 : b - 8'd1;
          replay_shadow();
        end
      end
      default: begin
        // run of the byte before the escape; the count becomes the new previous byte
        fill         = last_literal;
        last_literal = b;
        parse_ph     = PH_BODY;
        for (int k = 0; k < int'(b) && parse_ph == PH_BODY; k++) place_tile(fill);
      end
    endcase
  endfunction

  // Work out every word that one accepted input should produce
  function automatic void predict_words(logic [1:0] cmd, logic [7:0] b);
    item_writes.delete();
    case (cmd)
      CMD_DATA: decode_byte(b);
      CMD_REPLAY: begin
        if (!level_over && columns_owed != 0) begin
          columns_owed--;
          replay_shadow();
        end
      end
      CMD_RESTART: decoder_clear();
      default: ;
    endcase
    if (item_writes.size() == 0) log_write(row_ptr, 8'd0, 1'b0);
    item_writes[item_writes.size() - 1].last = 1'b1;
    foreach (item_writes[i]) expected_writes.push_back(item_writes[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one word after a random gap and hold it until taken
  task automatic send_word(input logic [1:0] cmd, input logic [7:0] b);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_words(cmd, b);
    items_sent++;
  endtask

  // Drop valid and let every expected word come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic test_level_start_replay();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // replay count zero right after reset replays the all-zero column once
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd0);
    wait_drained();
  endtask

  task automatic test_literals_and_runs();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_word(CMD_DATA, 8'd0);
    send_word(CMD_DATA, 8'd254);
    // zero-length run, single run, then a run clipped at the column end
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd0);
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd1);
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd255);
    wait_drained();
  endtask

  task automatic test_column_replay();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd2);
    // data is ignored while replays are owed
    send_word(CMD_DATA, 8'd7);
    send_word(CMD_REPLAY, 8'd0);
    // nothing owed any more
    send_word(CMD_REPLAY, 8'd0);
    wait_drained();
  endtask

  task automatic test_level_end();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    send_word(CMD_UNUSED, 8'd0);
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, ESCAPE_BYTE);
    // data and replay after the end marker are ignored
    send_word(CMD_DATA, 8'd9);
    send_word(CMD_REPLAY, 8'd0);
    send_word(CMD_RESTART, 8'd0);
    send_word(CMD_DATA, ESCAPE_BYTE);
    send_word(CMD_DATA, 8'd255);
    send_word(CMD_REPLAY, 8'd0);
    send_word(CMD_RESTART, 8'd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_requests++;
    // keep offering while the output is held off
    for (int i = 0; i < 16; i++) begin
      send_word(CMD_DATA, (i % 4 == 3) ? ESCAPE_BYTE : 8'($urandom_range(0, 254)));
    end
    wait_drained();
  endtask

  // Mostly well-formed level streams steered by the shadow state, some noise
  task automatic test_random_stream(input int count);
    logic [1:0] cmd;
    logic [7:0] b;
    int         pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      cmd  = CMD_DATA;
      b    = 8'($urandom_range(0, 254));
      if (pick < 6) begin
        cmd = 2'($urandom_range(0, 3));
        b   = 8'($urandom_range(0, 255));
      end else if (level_over) begin
        cmd = CMD_RESTART;
      end else if (columns_owed != 0) begin
        if (pick >= 16) cmd = CMD_REPLAY;
        else if (pick >= 12 && columns_owed > 16) cmd = CMD_RESTART;
      end else begin
        case (parse_ph)
          PH_START, PH_BODY: if (pick >= 75) b = ESCAPE_BYTE;
          PH_START_ESC: begin
            if (pick < 10) b = ESCAPE_BYTE;
            else if (pick < 20) b = 8'($urandom_range(0, 255));
            else b = 8'($urandom_range(0, 4));
          end
          default: b = (pick < 25) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6));
        endcase
      end
      send_word(cmd, b);
    end
    wait_drained();
  endtask

  // Output ready: random stalls per word, plus long hold-offs on request
  always @(posedge clk_i) begin : rx_pace
    int draw;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= (hold_left == 1);
    end else if (hold_requests != holds_seen) begin
      holds_seen    <= hold_requests;
      hold_left     <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait       <= rx_wait - 1;
      m_axis_tready <= (rx_wait == 1);
    end else if (m_axis_tvalid && m_axis_tready) begin
      draw          = rx_idle_on ? $urandom_range(0, 12) : 0;
      rx_wait       <= draw;
      m_axis_tready <= (draw == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each taken word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    tile_write_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected word: tdata=%h tuser=%b tlast=%b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        words_checked++;
        check_field("column", 8'(want.column), 8'(m_axis_tdata[4:0]));
        check_field("row", 8'(want.row), 8'(m_axis_tdata[9:5]));
        check_field("tile", want.tile, m_axis_tdata[17:10]);
        check_field("tile_valid", 8'(want.tile_valid), 8'(m_axis_tuser));
        check_field("last", 8'(want.last), 8'(m_axis_tlast));
        check_field("level_ended", 8'(want.level_ended), 8'(m_axis_tdata[18]));
        check_field("repeats_left", want.repeats_left, m_axis_tdata[26:19]);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    decoder_clear();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_level_start_replay();
    test_literals_and_runs();
    test_column_replay();
    test_level_end();
    test_backpressure();
    test_random_stream(290);
    $display("Sent %0d input words, checked %0d result words", items_sent, words_checked);
    $display("Column index wrapped %0d times, end of level decoded %0d times",
             column_wraps, level_ends);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
